@@ rtl/tdsu_pkg.sv @@
// ----------------------------------------------------------------------------
// tdsu_pkg
// Shared types and constants for the two-stage divider search unit.
// ----------------------------------------------------------------------------
package tdsu_pkg;

   // Field widths of the request and response words
   localparam int RATE_W   = 32;
   localparam int FIRST_W  = 6;
   localparam int SECOND_W = 5;

   // Dividend width of the shared divider: a rate plus half a divisor
   localparam int NUM_W = RATE_W + 1;

   // Default search limits
   localparam int FIRST_DIV_MAX_DEF  = 63;
   localparam int SECOND_DIV_MAX_DEF = 31;

   typedef struct packed {
      logic [RATE_W-1:0] target_rate;
      logic [RATE_W-1:0] source_rate;
   } tdsu_req_type;

   typedef struct packed {
      logic [FIRST_W-1:0]  first_divisor;
      logic [SECOND_W-1:0] second_divisor;
      logic [RATE_W-1:0]   achieved_rate;
   } tdsu_rsp_type;

   // Status of the shared divider toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } tdsu_div_stat_type;

endpackage

@@ rtl/tdsu_divider.sv @@
// ----------------------------------------------------------------------------
// tdsu_divider
// Restoring radix-2 divider, one quotient bit per cycle. Takes its operands
// on start and pulses done once the quotient is complete.
// ----------------------------------------------------------------------------
module tdsu_divider
   import tdsu_pkg::*;
#(
   parameter int DEN_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic [NUM_W-1:0]  quotient,
   output tdsu_div_stat_type stat
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             fits;

   // One restoring step: shift in the next dividend bit, try to subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
   end

   // Advance the iteration
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ rtl/two_stage_divider_search_unit.sv @@
// ----------------------------------------------------------------------------
// two_stage_divider_search_unit
// Finds the first/second divisor pair whose rounded output rate lies
// closest to a target rate, searching every pair in order.
// ----------------------------------------------------------------------------
// One request word is taken at a time; req_ready stays low until the
// response word has been taken. Every pair is evaluated with a single
// shared bit-serial divider: one division per first divisor and one per
// pair, each producing a 33-bit quotient. The default limits are 63 and
// 31. Earlier pairs win ties; a zero source rate returns pair (1,1) with
// rate 0.
// ----------------------------------------------------------------------------
module two_stage_divider_search_unit
   import tdsu_pkg::*;
#(
   parameter int FIRST_DIV_MAX  = FIRST_DIV_MAX_DEF,
   parameter int SECOND_DIV_MAX = SECOND_DIV_MAX_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  tdsu_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output tdsu_rsp_type rsp_data
);

   localparam int D0_W  = $clog2(FIRST_DIV_MAX + 1);
   localparam int D1_W  = $clog2(SECOND_DIV_MAX + 1);
   localparam int DEN_W = (D0_W > D1_W) ? D0_W : D1_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_OUTER = 4'b0010,
      ST_INNER = 4'b0100,
      ST_DONE  = 4'b1000
   } tdsu_state_type;

   tdsu_state_type    state_ff, state_in;
   logic [RATE_W-1:0] target_ff, target_in;
   logic [RATE_W-1:0] source_ff, source_in;
   logic [RATE_W-1:0] stage_ff, stage_in;
   logic [D0_W-1:0]   d0_ff, d0_in;
   logic [D1_W-1:0]   d1_ff, d1_in;
   logic              have_ff, have_in;
   logic [RATE_W-1:0] min_err_ff, min_err_in;
   logic [RATE_W-1:0] pick_rate_ff, pick_rate_in;
   logic [D0_W-1:0]   best_d0_ff, best_d0_in;
   logic [D1_W-1:0]   best_d1_ff, best_d1_in;
   logic              go_ff, go_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;

   logic [NUM_W-1:0]  quotient;
   tdsu_div_stat_type div_stat;
   logic [RATE_W-1:0] rate;
   logic [RATE_W-1:0] err;
   logic [D0_W-1:0]   d0_next;
   logic [D1_W-1:0]   d1_next;
   logic              d0_last;
   logic              d1_last;

   tdsu_divider #(
      .DEN_W(DEN_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (go_ff),
      .num     (num_ff),
      .den     (den_ff),
      .quotient(quotient),
      .stat    (div_stat)
   );

   // Rounded quotients never exceed the dividend, so the top bit is clear
   always_comb begin
      rate    = quotient[RATE_W-1:0];
      err     = (rate >= target_ff) ? (rate - target_ff) : (target_ff - rate);
      d0_next = d0_ff + D0_W'(1);
      d1_next = d1_ff + D1_W'(1);
      d0_last = (d0_ff == D0_W'(FIRST_DIV_MAX));
      d1_last = (d1_ff == D1_W'(SECOND_DIV_MAX));
   end

   // Sequence the search over all divisor pairs
   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      source_in    = source_ff;
      stage_in     = stage_ff;
      d0_in        = d0_ff;
      d1_in        = d1_ff;
      have_in      = have_ff;
      min_err_in   = min_err_ff;
      pick_rate_in = pick_rate_ff;
      best_d0_in   = best_d0_ff;
      best_d1_in   = best_d1_ff;
      go_in        = 1'b0;
      num_in       = num_ff;
      den_in       = den_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               target_in    = req_data.target_rate;
               source_in    = req_data.source_rate;
               d0_in        = D0_W'(1);
               have_in      = 1'b0;
               best_d0_in   = D0_W'(1);
               best_d1_in   = D1_W'(1);
               pick_rate_in = req_data.source_rate;
               go_in        = 1'b1;
               num_in       = {1'b0, req_data.source_rate};
               den_in       = DEN_W'(1);
               state_in     = ST_OUTER;
            end
         end
         ST_OUTER: begin
            // First-stage rate is ready: start the inner sweep at d1 = 1
            if (div_stat.done) begin
               stage_in = rate;
               d1_in    = D1_W'(1);
               go_in    = 1'b1;
               num_in   = {1'b0, rate};
               den_in   = DEN_W'(1);
               state_in = ST_INNER;
            end
         end
         ST_INNER: begin
            if (div_stat.done) begin
               // Keep the first pair with strictly smaller error
               if (!have_ff || (err < min_err_ff)) begin
                  have_in      = 1'b1;
                  min_err_in   = err;
                  pick_rate_in = rate;
                  best_d0_in   = d0_ff;
                  best_d1_in   = d1_ff;
               end
               if (!d1_last) begin
                  d1_in  = d1_next;
                  go_in  = 1'b1;
                  num_in = {1'b0, stage_ff} + NUM_W'(d1_next >> 1);
                  den_in = DEN_W'(d1_next);
               end else if (!d0_last) begin
                  d0_in    = d0_next;
                  go_in    = 1'b1;
                  num_in   = {1'b0, source_ff} + NUM_W'(d0_next >> 1);
                  den_in   = DEN_W'(d0_next);
                  state_in = ST_OUTER;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // Hold the response word until taken
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         have_ff  <= have_in;
      end
      target_ff    <= target_in;
      source_ff    <= source_in;
      stage_ff     <= stage_in;
      d0_ff        <= d0_in;
      d1_ff        <= d1_in;
      min_err_ff   <= min_err_in;
      pick_rate_ff <= pick_rate_in;
      best_d0_ff   <= best_d0_in;
      best_d1_ff   <= best_d1_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   // Divisors wider than the fields are masked to the field width
   assign rsp_data.first_divisor  = FIRST_W'(best_d0_ff);
   assign rsp_data.second_divisor = SECOND_W'(best_d1_ff);
   assign rsp_data.achieved_rate  = pick_rate_ff;

endmodule
